// ----- hw/rtl/bpb64_pkg.sv -----
// Shared widths, group counting and the base64 character map for the bit packer.
// No dependencies; imported by bitfield_packer_base64_encoder.
package bpb64_pkg;

    localparam int FIELD_W     = 31;            // field value width
    localparam int WIDTH_W     = 5;             // field width code width
    localparam int SYM_W       = 7;             // ASCII character width
    localparam int GROUP_BITS  = 6;             // bits per base64 character
    localparam int PEND_W      = 5;             // carried bits, at most one short group
    localparam int PCNT_W      = 3;             // count of carried bits, 0..5
    localparam int ACC_W       = PEND_W + FIELD_W;
    localparam int TOTAL_W     = 6;             // carried plus new bits, 0..36
    localparam int CHR_CNT_W   = 3;             // characters per word, 0..6
    localparam int MAX_FIELD_WIDTH_DEF = 31;

    // Map one 6-bit group to its base64 ASCII character.
    function automatic logic [SYM_W-1:0] b64_char(input logic [GROUP_BITS-1:0] grp);
        logic [SYM_W-1:0] chr;
        begin
            if (grp < 6'd26) begin
                chr = 7'h41 + {1'b0, grp};
            end else if (grp < 6'd52) begin
                chr = 7'h61 + {1'b0, grp} - 7'd26;
            end else if (grp < 6'd62) begin
                chr = 7'h30 + {1'b0, grp} - 7'd52;
            end else if (grp == 6'd62) begin
                chr = 7'h2B;
            end else begin
                chr = 7'h2F;
            end
            return chr;
        end
    endfunction

    // Number of complete groups in a bit count of 0..36.
    function automatic logic [CHR_CNT_W-1:0] full_groups(input logic [TOTAL_W-1:0] bits);
        logic [CHR_CNT_W-1:0] ng;
        begin
            if (bits >= 6'd36) begin
                ng = 3'd6;
            end else if (bits >= 6'd30) begin
                ng = 3'd5;
            end else if (bits >= 6'd24) begin
                ng = 3'd4;
            end else if (bits >= 6'd18) begin
                ng = 3'd3;
            end else if (bits >= 6'd12) begin
                ng = 3'd2;
            end else if (bits >= 6'd6) begin
                ng = 3'd1;
            end else begin
                ng = 3'd0;
            end
            return ng;
        end
    endfunction

endpackage

// ----- hw/rtl/bitfield_packer_base64_encoder.sv -----
// LSB-first bit packer with base64 character output, top level.
// Depends on bpb64_pkg for widths, group counting and the character map.
//
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------------
//  in      | i_in_valid / o_in_ready   | i_field_value, i_field_width, i_last_field
//  out     | o_out_valid / i_out_ready | o_symbol, o_last_symbol
//
// A word is packed into a 36-bit job register in the cycle it is accepted;
// the job then drains one character per cycle into the output register
// while the output is not stalled. A word holds the input until its last
// character is loaded; the one-character-per-cycle output port sets the pace.
// A stall on the output holds the output register and the job register.
// Reset (synchronous, active low) clears carried bits, job and output valid.
module bitfield_packer_base64_encoder
    import bpb64_pkg::*;
#(
    parameter int MAX_FIELD_WIDTH = MAX_FIELD_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [FIELD_W-1:0] i_field_value,
    input  logic [WIDTH_W-1:0] i_field_width,
    input  logic               i_last_field,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [SYM_W-1:0]   o_symbol,
    output logic               o_last_symbol
);

    localparam logic [WIDTH_W-1:0] MaxW = WIDTH_W'(MAX_FIELD_WIDTH);

    // carried bits between words
    logic [PEND_W-1:0]    r_pend_bits;
    logic [PCNT_W-1:0]    r_pend_cnt;
    // job being drained
    logic [ACC_W-1:0]     r_job_acc;
    logic [CHR_CNT_W-1:0] r_job_cnt;
    logic                 r_job_last;
    // output register
    logic                 r_out_valid;
    logic [SYM_W-1:0]     r_symbol;
    logic                 r_last_symbol;

    logic [WIDTH_W-1:0]   w_sat;
    logic [FIELD_W-1:0]   val_mask;
    logic [ACC_W-1:0]     n_acc;
    logic [TOTAL_W-1:0]   total;
    logic [CHR_CNT_W-1:0] n_groups;
    logic [CHR_CNT_W-1:0] n_chars;
    logic [ACC_W-1:0]     rem_acc;
    logic                 out_load;
    logic                 job_free;
    logic                 in_accept;

    always_comb begin
        w_sat    = (i_field_width > MaxW) ? MaxW : i_field_width;
        val_mask = ~({FIELD_W{1'b1}} << w_sat);
        n_acc    = {{FIELD_W{1'b0}}, r_pend_bits}
                 | ({{PEND_W{1'b0}}, i_field_value & val_mask} << r_pend_cnt);
        total    = TOTAL_W'(r_pend_cnt) + TOTAL_W'(w_sat);
        n_groups = full_groups(total);
        // drop the groups sent in this word to find the leftover bits
        rem_acc  = n_acc >> (GROUP_BITS * int'(n_groups));
        // any leftover bits add one padded character at the end mark
        n_chars  = n_groups + CHR_CNT_W'(i_last_field && (rem_acc[PEND_W-1:0] != '0
                   || total != TOTAL_W'(GROUP_BITS) * TOTAL_W'(n_groups)));
    end

    assign out_load  = (r_job_cnt != '0) && (!r_out_valid || i_out_ready);
    assign job_free  = (r_job_cnt == '0) || ((r_job_cnt == CHR_CNT_W'(1)) && out_load);
    assign in_accept = i_in_valid && job_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_job_cnt   <= '0;
            r_job_last  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_job_acc  <= n_acc;
                r_job_cnt  <= n_chars;
                r_job_last <= i_last_field;
                if (i_last_field) begin
                    r_pend_bits <= '0;
                    r_pend_cnt  <= '0;
                end else begin
                    r_pend_bits <= rem_acc[PEND_W-1:0];
                    r_pend_cnt  <= PCNT_W'(total - TOTAL_W'(GROUP_BITS) * TOTAL_W'(n_groups));
                end
            end else if (out_load) begin
                // advance to the next group
                r_job_acc <= r_job_acc >> GROUP_BITS;
                r_job_cnt <= r_job_cnt - CHR_CNT_W'(1);
            end

            if (out_load) begin
                r_out_valid   <= 1'b1;
                r_symbol      <= b64_char(r_job_acc[GROUP_BITS-1:0]);
                r_last_symbol <= r_job_last && (r_job_cnt == CHR_CNT_W'(1));
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready    = job_free;
    assign o_out_valid   = r_out_valid;
    assign o_symbol      = r_symbol;
    assign o_last_symbol = r_last_symbol;

    a_job_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_cnt <= CHR_CNT_W'(6))
        else $error("job character count out of range");

    a_pend_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt < PCNT_W'(GROUP_BITS))
        else $error("carried bit count reached a full group");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_last_field |=> r_pend_cnt == '0 && r_pend_bits == '0)
        else $error("carried bits not cleared after end mark");

    a_ready_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_job_cnt <= CHR_CNT_W'(1))
        else $error("input ready while job still has characters");

endmodule
